// ----- design/ehs_pkg.sv -----
// Package for the edge hash set: shared constants and the command and status
// structs that join the controller and the datapath. No dependencies.
package ehs_pkg;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned MIX_SHIFT = 8;
  localparam int unsigned SLOT_W    = 12;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned EFF_W     = 5;
  localparam logic [KEY_W-1:0] HASH_MULT = 32'd49157;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic load;
    logic mix;
    logic mul;
    logic probe_chk;
    logic ins_wr;
    logic slot_rd;
    logic slot_wr;
    logic clr;
  } ehs_cmd_t;

  typedef struct packed {
    logic is_read;
    logic probe_stop;
    logic clr_last;
  } ehs_status_t;

endpackage

// ----- design/edge_hash_set_linear_probe_top.sv -----
// Top level of the edge hash set: joins the controller and the datapath.
// Depends on ehs_pkg, ehs_ctrl and ehs_datapath.
//
// Usage: a transaction is accepted at a rising edge with start high and busy
// low. With in_req_type insert, the edge (in_vertex_a, in_vertex_b) is hashed
// and stored by linear probing; with in_req_type read, slot in_slot_index is
// returned and cleared. Every transaction gives one result, held on the out_
// ports for one cycle and marked by out_valid; the receiver cannot stall.
// An insert probes slots in turn, each with a registered memory read and then
// the compare, and its result is shown with busy already low, so the next
// transaction can be taken at the edge ending the result cycle. A read passes
// through ST_MIX, ST_SLOT_RD and ST_SLOT_WR before its result is shown.
// The table size register is written through cfg_valid and cfg_ready, which
// is always high; write it only while the block is idle.
// After reset the block sweeps all 2**TABLE_DEPTH_LOG2 slots of the slot memory
// to zero, one slot per cycle, with busy high.
module edge_hash_set_linear_probe_top #(
  parameter int unsigned TABLE_DEPTH_LOG2 = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [ehs_pkg::HALF_W-1:0]  in_vertex_a,
  input  logic [ehs_pkg::HALF_W-1:0]  in_vertex_b,
  input  logic [ehs_pkg::SLOT_W-1:0]  in_slot_index,
  output logic                        out_valid,
  output logic                        out_slot_valid,
  output logic [ehs_pkg::HALF_W-1:0]  out_low_vertex,
  output logic [ehs_pkg::HALF_W-1:0]  out_high_vertex,
  output logic [ehs_pkg::SLOT_W-1:0]  out_slot_used,
  output logic                        out_already_present,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ehs_pkg::CFG_W-1:0]   cfg_table_size_log2
);

  ehs_pkg::ehs_cmd_t    cmd;
  ehs_pkg::ehs_status_t status;
  logic                 accept;

  assign accept = start && !busy;

  ehs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ehs_datapath #(
    .TABLE_DEPTH_LOG2 (TABLE_DEPTH_LOG2)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_req_type         (in_req_type),
    .in_vertex_a         (in_vertex_a),
    .in_vertex_b         (in_vertex_b),
    .in_slot_index       (in_slot_index),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_table_size_log2 (cfg_table_size_log2),
    .out_valid           (out_valid),
    .out_slot_valid      (out_slot_valid),
    .out_low_vertex      (out_low_vertex),
    .out_high_vertex     (out_high_vertex),
    .out_slot_used       (out_slot_used),
    .out_already_present (out_already_present)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_present_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_already_present) |-> out_slot_valid)
    else $error("already_present without slot_valid");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_slot_valid) |-> (out_low_vertex == '0 && out_high_vertex == '0))
    else $error("empty slot result carries nonzero vertices");

endmodule

// ----- design/ehs_ctrl.sv -----
// Controller for the edge hash set: sequences clearing, hashing, probing and
// slot reads. Depends on ehs_pkg for the command and status structs.
module ehs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ehs_pkg::ehs_status_t status,
  output ehs_pkg::ehs_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MIX, ST_MUL, ST_PROBE_RD, ST_PROBE_CHK,
    ST_INS_WR, ST_SLOT_RD, ST_SLOT_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        if (status.is_read) begin
          state_nxt = ST_SLOT_RD;
        end else begin
          cmd.mix   = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_PROBE_RD;
      end
      ST_PROBE_RD: begin
        state_nxt = ST_PROBE_CHK;
      end
      ST_PROBE_CHK: begin
        cmd.probe_chk = 1'b1;
        state_nxt     = status.probe_stop ? ST_INS_WR : ST_PROBE_RD;
      end
      ST_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SLOT_RD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = ST_SLOT_WR;
      end
      ST_SLOT_WR: begin
        cmd.slot_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ----- design/ehs_datapath.sv -----
// Datapath for the edge hash set: key forming, hash multiplier, probe
// counter, slot memory and result registers. Depends on ehs_pkg.
module ehs_datapath #(
  parameter int unsigned TABLE_DEPTH_LOG2 = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ehs_pkg::ehs_cmd_t           cmd,
  output ehs_pkg::ehs_status_t        status,
  input  logic                        in_req_type,
  input  logic [ehs_pkg::HALF_W-1:0]  in_vertex_a,
  input  logic [ehs_pkg::HALF_W-1:0]  in_vertex_b,
  input  logic [ehs_pkg::SLOT_W-1:0]  in_slot_index,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ehs_pkg::CFG_W-1:0]   cfg_table_size_log2,
  output logic                        out_valid,
  output logic                        out_slot_valid,
  output logic [ehs_pkg::HALF_W-1:0]  out_low_vertex,
  output logic [ehs_pkg::HALF_W-1:0]  out_high_vertex,
  output logic [ehs_pkg::SLOT_W-1:0]  out_slot_used,
  output logic                        out_already_present
);

  localparam int unsigned P     = TABLE_DEPTH_LOG2;
  localparam int unsigned DEPTH = 1 << TABLE_DEPTH_LOG2;
  localparam int unsigned KW    = ehs_pkg::KEY_W;
  localparam int unsigned HW    = ehs_pkg::HALF_W;
  localparam int unsigned SW    = ehs_pkg::SLOT_W;

  logic [KW-1:0] mem [DEPTH];

  logic [ehs_pkg::CFG_W-1:0] cfg_r;
  logic [ehs_pkg::EFF_W-1:0] eff;
  logic [P-1:0]  mask;
  logic          req_r;
  logic [KW-1:0] key_r;
  logic [KW-1:0] mix_r;
  logic [KW-1:0] prod;
  logic [P-1:0]  h_r;
  logic [P-1:0]  pos_r;
  logic [P-1:0]  i_r;
  logic [P-1:0]  i_inc;
  logic [SW-1:0] idx_r;
  logic [KW-1:0] rdata_r;
  logic          found_r;
  logic [P-1:0]  clr_r;
  logic [HW-1:0] lo;
  logic [HW-1:0] hi;
  logic          hit_eq;
  logic          hit;
  logic          in_range;
  logic [SW+P-1:0] idx_ext;
  logic [SW+P-1:0] pos_ext;
  logic [P-1:0]  idx_addr;
  logic [P-1:0]  rd_addr;
  logic          we;
  logic [P-1:0]  wr_addr;
  logic [KW-1:0] wr_data;
  logic [KW-1:0] content;

  logic                out_valid_r;
  logic                out_slot_valid_r;
  logic [HW-1:0]       out_low_r;
  logic [HW-1:0]       out_high_r;
  logic [SW-1:0]       out_slot_r;
  logic                out_present_r;

  always_comb begin
    if (cfg_r == '0) begin
      eff = ehs_pkg::EFF_W'(1);
    end else if ({1'b0, cfg_r} > ehs_pkg::EFF_W'(P)) begin
      eff = ehs_pkg::EFF_W'(P);
    end else begin
      eff = {1'b0, cfg_r};
    end
  end

  always_comb begin
    for (int j = 0; j < P; j++) begin
      mask[j] = (ehs_pkg::EFF_W'(j) < eff);
    end
  end

  assign lo       = (in_vertex_a < in_vertex_b) ? in_vertex_a : in_vertex_b;
  assign hi       = (in_vertex_a < in_vertex_b) ? in_vertex_b : in_vertex_a;
  assign prod     = mix_r * ehs_pkg::HASH_MULT;
  assign i_inc    = i_r + P'(1);
  assign hit_eq   = (rdata_r != '0) && (rdata_r == key_r);
  assign hit      = (rdata_r == '0) || hit_eq;
  assign idx_ext  = {{P{1'b0}}, idx_r};
  assign pos_ext  = {{SW{1'b0}}, pos_r};
  assign idx_addr = idx_ext[P-1:0];
  assign in_range = ((idx_r >> eff) == '0);
  assign rd_addr  = cmd.slot_rd ? idx_addr : pos_r;
  assign content  = in_range ? rdata_r : '0;

  assign status.is_read    = req_r;
  assign status.probe_stop = hit || (i_inc == mask);
  assign status.clr_last   = &clr_r;

  always_comb begin
    we      = 1'b0;
    wr_addr = pos_r;
    wr_data = key_r;
    if (cmd.clr) begin
      we      = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (cmd.ins_wr) begin
      we      = 1'b1;
    end else if (cmd.slot_wr && in_range) begin
      we      = 1'b1;
      wr_addr = idx_addr;
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      key_r <= {lo, hi};
      idx_r <= in_slot_index;
    end
    if (cmd.mix) begin
      mix_r <= key_r + (key_r << ehs_pkg::MIX_SHIFT);
    end
    if (cmd.mul) begin
      h_r   <= prod[P-1:0];
      pos_r <= prod[P-1:0] & mask;
      i_r   <= '0;
    end
    if (cmd.probe_chk) begin
      found_r <= hit_eq;
      if (!hit) begin
        i_r   <= i_inc;
        pos_r <= (h_r + i_inc) & mask;
      end
    end
    if (cmd.ins_wr) begin
      out_slot_valid_r <= 1'b1;
      out_low_r        <= key_r[KW-1:HW];
      out_high_r       <= key_r[HW-1:0];
      out_slot_r       <= pos_ext[SW-1:0];
      out_present_r    <= found_r;
    end else if (cmd.slot_wr) begin
      out_slot_valid_r <= (content != '0);
      out_low_r        <= content[KW-1:HW];
      out_high_r       <= content[HW-1:0];
      out_slot_r       <= idx_r;
      out_present_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= ehs_pkg::CFG_W'(12);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_table_size_log2;
      end
      if (cmd.clr) begin
        clr_r <= clr_r + P'(1);
      end
      out_valid_r <= cmd.ins_wr || cmd.slot_wr;
    end
  end

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_slot_valid      = out_slot_valid_r;
  assign out_low_vertex      = out_low_r;
  assign out_high_vertex     = out_high_r;
  assign out_slot_used       = out_slot_r;
  assign out_already_present = out_present_r;

endmodule
